// ----- hw/rtl/mp2_pkg.sv -----
// shared types, constants and window tracking functions for the max pool block
package mp2_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned SPAN_W     = 11;
  localparam int unsigned MAX_WINDOW = 8;
  localparam int unsigned MAX_DIM    = 256;
  localparam int unsigned SLOT_ROW_W = $clog2(MAX_WINDOW);
  localparam int unsigned RAM_AW     = SLOT_ROW_W + CNT_W;
  localparam int unsigned RAM_DEPTH  = 1 << RAM_AW;
  localparam int unsigned RAM_W      = SAMPLE_W + INDEX_W;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd4;

  // window coverage along one axis for the current position
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  lo;
    logic [SPAN_W-1:0] lo_s;
    logic [SPAN_W-1:0] end_nx;
    logic [CNT_W-1:0]  hi;
    logic [SPAN_W-1:0] start_nx;
  } axis_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] max_value;
    logic [INDEX_W-1:0]         argmax_index;
    logic [CNT_W-1:0]           out_row;
    logic [CNT_W-1:0]           out_col;
    logic                       plane_end;
  } res_t;

  function automatic axis_t axis_init(input logic [3:0] k, input logic [3:0] s,
                                      input logic [2:0] p);
    axis_t      a;
    logic [6:0] nxt;
    logic [2:0] q;
    q   = '0;
    nxt = {3'b000, s};
    // floor(p / s) by repeated addition, p is at most four
    for (int i = 0; i < 4; i++) begin
      if (nxt <= {4'b0000, p}) begin
        q   = q + 3'd1;
        nxt = nxt + {3'b000, s};
      end
    end
    a.pos      = '0;
    a.lo       = '0;
    a.lo_s     = '0;
    a.end_nx   = SPAN_W'(k) - SPAN_W'(p) - SPAN_W'(1);
    a.hi       = CNT_W'(q);
    a.start_nx = SPAN_W'(nxt) - SPAN_W'(p);
    return a;
  endfunction

  function automatic axis_t axis_step(input axis_t a, input logic [3:0] s);
    axis_t b;
    b     = a;
    b.pos = a.pos + POS_W'(1);
    if (SPAN_W'(a.pos) == a.end_nx) begin
      b.lo     = a.lo + CNT_W'(1);
      b.lo_s   = a.lo_s + SPAN_W'(s);
      b.end_nx = a.end_nx + SPAN_W'(s);
    end
    if (SPAN_W'(a.pos) + SPAN_W'(1) == a.start_nx) begin
      b.hi       = a.hi + CNT_W'(1);
      b.start_nx = a.start_nx + SPAN_W'(s);
    end
    return b;
  endfunction

endpackage

// ----- hw/rtl/mp2_if.sv -----
// stream and configuration channel interfaces of the max pool block
interface mp2_in_if import mp2_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

interface mp2_out_if import mp2_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] max_value;
  logic [INDEX_W-1:0]         argmax_index;
  logic [CNT_W-1:0]           out_row;
  logic [CNT_W-1:0]           out_col;
  logic                       run_last;
  logic                       plane_end;
  modport source (output valid, max_value, argmax_index, out_row, out_col, run_last,
                  plane_end, input ready);
  modport sink (input valid, max_value, argmax_index, out_row, out_col, run_last,
                plane_end, output ready);
endinterface

interface mp2_cfg_if import mp2_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/mp2_ram.sv -----
// generic single write port ram with registered read
module mp2_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/max_pool_2d_argmax.sv -----
// 2d max pooling with argmax over a raster stream of 16-bit samples
// each sample is taken only in idle and then visits every window it touches in turn,
// using the single compare unit and the partial maximum ram it reads and writes
// results leave through an output register; the next sample is taken while one waits there
// reset clears the sequencer, counters and registers (window 2, step 2, pad 0, 32 x 32),
// then the restart flag re-arms the window trackers; ram contents need no clearing
module max_pool_2d_argmax import mp2_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  mp2_in_if.sink    sample_i,
  mp2_out_if.source result_o,
  mp2_cfg_if.sink   cfg_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_UPD   = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       restart_q, restart_d;
  logic [3:0] win_q, win_d, step_q, step_d;
  logic [2:0] pad_q, pad_d;
  logic [DIM_W-1:0] rows_q, rows_d, cols_q, cols_d;

  axis_t row_q, row_d, col_q, col_d;
  logic [INDEX_W-1:0] lin_q, lin_d;
  logic signed [SAMPLE_W-1:0] smp_q, smp_d;
  logic [CNT_W-1:0]  oh_q, oh_d, ow_q, ow_d;
  logic [SPAN_W-1:0] hs0_q, hs0_d, ws0_q, ws0_d;

  logic pend_v_q, pend_v_d;
  res_t pend_q, pend_d;
  logic out_v_q, out_v_d, out_last_q, out_last_d;
  res_t out_q, out_d;

  // effective configuration
  logic [3:0] k_eff, s_eff;
  logic [2:0] half_k, p_eff;
  logic [DIM_W-1:0] h_eff, w_eff;
  logic [SPAN_W-1:0] lim_h, lim_w;

  always_comb begin
    k_eff  = (win_q == 4'd0) ? 4'd1 : ((win_q > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : win_q);
    s_eff  = (step_q == 4'd0) ? 4'd1 : step_q;
    half_k = 3'(k_eff >> 1);
    p_eff  = (pad_q > half_k) ? half_k : pad_q;
    h_eff  = (rows_q == '0) ? DIM_W'(1) : ((rows_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rows_q);
    w_eff  = (cols_q == '0) ? DIM_W'(1) : ((cols_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cols_q);
    lim_h  = SPAN_W'(h_eff) + SPAN_W'({p_eff, 1'b0});
    lim_w  = SPAN_W'(w_eff) + SPAN_W'({p_eff, 1'b0});
  end

  // partial maximum store, slot row is the output row modulo the window limit
  logic ram_we, ram_re;
  logic [RAM_AW-1:0] ram_addr;
  logic [RAM_W-1:0]  ram_wdata, ram_rdata;

  assign ram_addr = {oh_q[SLOT_ROW_W-1:0], ow_q};

  mp2_ram #(
    .WIDTH(RAM_W),
    .DEPTH(RAM_DEPTH)
  ) u_part_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_addr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_addr),
    .rdata_o(ram_rdata)
  );

  logic in_fire, cfg_fire, out_free;
  logic row_ok, col_ok;
  logic [SPAN_W-1:0] hs_cl, ws_cl, he, we, he_cl, we_cl;
  logic first_px, fin_row, fin_col, fin, last_row, last_col, greater, take, proceed;
  logic signed [SAMPLE_W-1:0] rd_max, new_max;
  logic [INDEX_W-1:0] rd_arg, new_arg;
  logic col_wrap, row_wrap;
  res_t cur_res;

  assign sample_i.ready = (state_q == S_IDLE) && !restart_q;
  assign cfg_i.ready    = 1'b1;
  assign in_fire        = sample_i.valid && sample_i.ready;
  assign cfg_fire       = cfg_i.valid;
  assign out_free       = !out_v_q || result_o.ready;

  always_comb begin
    row_ok   = (oh_q <= row_q.hi) && (hs0_q + SPAN_W'(k_eff) <= lim_h);
    col_ok   = (ow_q <= col_q.hi) && (ws0_q + SPAN_W'(k_eff) <= lim_w);
    hs_cl    = (hs0_q > SPAN_W'(p_eff)) ? hs0_q - SPAN_W'(p_eff) : '0;
    ws_cl    = (ws0_q > SPAN_W'(p_eff)) ? ws0_q - SPAN_W'(p_eff) : '0;
    he       = hs0_q + SPAN_W'(k_eff) - SPAN_W'(p_eff);
    we       = ws0_q + SPAN_W'(k_eff) - SPAN_W'(p_eff);
    he_cl    = (he > SPAN_W'(h_eff)) ? SPAN_W'(h_eff) : he;
    we_cl    = (we > SPAN_W'(w_eff)) ? SPAN_W'(w_eff) : we;
    first_px = (SPAN_W'(row_q.pos) == hs_cl) && (SPAN_W'(col_q.pos) == ws_cl);
    fin_row  = (SPAN_W'(row_q.pos) + SPAN_W'(1)) == he_cl;
    fin_col  = (SPAN_W'(col_q.pos) + SPAN_W'(1)) == we_cl;
    fin      = fin_row && fin_col;
    last_row = hs0_q + SPAN_W'(s_eff) + SPAN_W'(k_eff) > lim_h;
    last_col = ws0_q + SPAN_W'(s_eff) + SPAN_W'(k_eff) > lim_w;
    rd_max   = $signed(ram_rdata[RAM_W-1 -: SAMPLE_W]);
    rd_arg   = ram_rdata[INDEX_W-1:0];
    greater  = smp_q > rd_max;
    take     = first_px || greater;
    new_max  = take ? smp_q : rd_max;
    new_arg  = take ? lin_q : rd_arg;
    proceed  = !fin || !pend_v_q || out_free;
    col_wrap = {1'b0, col_q.pos} == w_eff - DIM_W'(1);
    row_wrap = {1'b0, row_q.pos} == h_eff - DIM_W'(1);
    cur_res.max_value    = new_max;
    cur_res.argmax_index = new_arg;
    cur_res.out_row      = oh_q;
    cur_res.out_col      = ow_q;
    cur_res.plane_end    = last_row && last_col;
  end

  assign ram_wdata = {new_max, new_arg};

  always_comb begin
    state_d    = state_q;
    restart_d  = restart_q;
    win_d      = win_q;
    step_d     = step_q;
    pad_d      = pad_q;
    rows_d     = rows_q;
    cols_d     = cols_q;
    row_d      = row_q;
    col_d      = col_q;
    lin_d      = lin_q;
    smp_d      = smp_q;
    oh_d       = oh_q;
    ow_d       = ow_q;
    hs0_d      = hs0_q;
    ws0_d      = ws0_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    out_v_d    = out_v_q && !result_o.ready;
    out_d      = out_q;
    out_last_d = out_last_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (restart_q) begin
          row_d     = axis_init(k_eff, s_eff, p_eff);
          col_d     = axis_init(k_eff, s_eff, p_eff);
          lin_d     = '0;
          restart_d = 1'b0;
        end else if (in_fire) begin
          smp_d   = sample_i.sample;
          oh_d    = row_q.lo;
          hs0_d   = row_q.lo_s;
          ow_d    = col_q.lo;
          ws0_d   = col_q.lo_s;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!row_ok) begin
          state_d = S_FLUSH;
        end else if (!col_ok) begin
          oh_d  = oh_q + CNT_W'(1);
          hs0_d = hs0_q + SPAN_W'(s_eff);
          ow_d  = col_q.lo;
          ws0_d = col_q.lo_s;
        end else begin
          ram_re  = 1'b1;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (proceed) begin
          ram_we = 1'b1;
          if (fin) begin
            // previous result of this word is not the last one
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_d      = pend_q;
              out_last_d = 1'b0;
            end
            pend_v_d = 1'b1;
            pend_d   = cur_res;
          end
          ow_d    = ow_q + CNT_W'(1);
          ws0_d   = ws0_q + SPAN_W'(s_eff);
          state_d = S_CHECK;
        end
      end
      S_FLUSH: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            out_v_d    = 1'b1;
            out_d      = pend_q;
            out_last_d = 1'b1;
            pend_v_d   = 1'b0;
          end
          if (col_wrap) begin
            col_d = axis_init(k_eff, s_eff, p_eff);
            row_d = row_wrap ? axis_init(k_eff, s_eff, p_eff) : axis_step(row_q, s_eff);
          end else begin
            col_d = axis_step(col_q, s_eff);
          end
          lin_d   = (col_wrap && row_wrap) ? '0 : lin_q + INDEX_W'(1);
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_fire) begin
      restart_d = 1'b1;
      case (cfg_i.index)
        REG_WINDOW: win_d  = cfg_i.data[3:0];
        REG_STEP:   step_d = cfg_i.data[3:0];
        REG_PAD:    pad_d  = cfg_i.data[2:0];
        REG_ROWS:   rows_d = cfg_i.data;
        REG_COLS:   cols_d = cfg_i.data;
        default: begin
          restart_d = restart_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      restart_q  <= 1'b1;
      win_q      <= 4'd2;
      step_q     <= 4'd2;
      pad_q      <= 3'd0;
      rows_q     <= DIM_W'(32);
      cols_q     <= DIM_W'(32);
      row_q      <= '0;
      col_q      <= '0;
      lin_q      <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      restart_q  <= restart_d;
      win_q      <= win_d;
      step_q     <= step_d;
      pad_q      <= pad_d;
      rows_q     <= rows_d;
      cols_q     <= cols_d;
      row_q      <= row_d;
      col_q      <= col_d;
      lin_q      <= lin_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q  <= smp_d;
    oh_q   <= oh_d;
    ow_q   <= ow_d;
    hs0_q  <= hs0_d;
    ws0_q  <= ws0_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign result_o.valid        = out_v_q;
  assign result_o.max_value    = out_q.max_value;
  assign result_o.argmax_index = out_q.argmax_index;
  assign result_o.out_row      = out_q.out_row;
  assign result_o.out_col      = out_q.out_col;
  assign result_o.run_last     = out_last_q;
  assign result_o.plane_end    = out_q.plane_end;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_v_q)
    else $error("result still held back when the sequencer is idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.plane_end |-> result_o.run_last)
    else $error("plane end on a result that is not the last of its word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |-> (oh_q - row_q.lo) < CNT_W'(MAX_WINDOW))
    else $error("open window rows alias in the partial maximum store");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !restart_q |-> ({1'b0, col_q.pos} < w_eff) && ({1'b0, row_q.pos} < h_eff))
    else $error("plane position outside the plane");

endmodule
